// ===== hw/rtl/arx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARX cipher shared definitions
// Opcodes, result kinds, round count, controller command and status bundles.
// ----------------------------------------------------------------------------
package arx_pkg;

  // Number of cipher rounds and width of a round-key slot index
  localparam int ROUNDS = 27;
  localparam int KEY_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  // Field widths fixed by the interface
  localparam int OP_W    = 3;
  localparam int IDX_W   = 6;
  localparam int WORD_W  = 32;
  localparam int BLOCK_W = 64;
  localparam int CNT_W   = 4;
  localparam int KIND_W  = 2;

  // Opcodes
  localparam logic [OP_W-1:0] OP_LOAD_KEY  = 3'd0;
  localparam logic [OP_W-1:0] OP_ENCRYPT   = 3'd1;
  localparam logic [OP_W-1:0] OP_DECRYPT   = 3'd2;
  localparam logic [OP_W-1:0] OP_CTR_START = 3'd3;
  localparam logic [OP_W-1:0] OP_CTR_DATA  = 3'd4;
  localparam logic [OP_W-1:0] OP_MAC_CLEAR = 3'd5;
  localparam logic [OP_W-1:0] OP_MAC_DATA  = 3'd6;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ENC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CTR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_MAC = 2'd3;

  // Source of the working block when a new item starts
  typedef enum logic [2:0] {
    SRC_BLOCK,
    SRC_CTR,
    SRC_MAC_MIX,
    SRC_MAC,
    SRC_ZERO
  } src_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              key_we;
    logic              ctr_start;
    logic              mac_clr;
    logic              blk_load;
    src_t              src;
    logic [KIND_W-1:0] kind;
    logic              round_en;
    logic              dec;
    logic [KEY_W-1:0]  key_sel;
    logic              push;
    logic              push_round;
    logic              ctr_adv;
    logic              mac_upd;
  } arx_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } arx_stat_t;

  // Mask of the valid low bytes; counts of eight and above keep all bytes
  function automatic logic [BLOCK_W-1:0] byte_mask(input logic [CNT_W-1:0] cnt);
    logic [BLOCK_W-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (cnt[3] || (CNT_W'(i) < cnt)) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/arx_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARX cipher controller
// Decodes each beat, sequences the rounds and hands results to the output.
// ----------------------------------------------------------------------------
module arx_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [arx_pkg::OP_W-1:0]    in_op,
  input  wire logic [arx_pkg::CNT_W-1:0]   in_byte_count,
  output logic                             in_stall,
  input  wire arx_pkg::arx_stat_t          stat,
  output arx_pkg::arx_cmd_t                cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  localparam logic [arx_pkg::KEY_W-1:0] LAST_RND = arx_pkg::KEY_W'(arx_pkg::ROUNDS - 1);

  state_t                      state_r;
  logic [arx_pkg::KEY_W-1:0]   rnd_r;
  logic                        dec_r;
  logic                        ctr_adv_r;
  logic                        mac_upd_r;
  logic                        accept;
  logic                        cnt_zero;
  logic                        last_rnd;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign cnt_zero = (in_byte_count == '0);
  assign last_rnd = (rnd_r == LAST_RND);

  // Build the datapath commands for this cycle
  always_comb begin
    cmd            = '0;
    cmd.src        = arx_pkg::SRC_BLOCK;
    cmd.dec        = dec_r;
    cmd.key_sel    = dec_r ? (LAST_RND - rnd_r) : rnd_r;
    cmd.ctr_adv    = ctr_adv_r;
    cmd.mac_upd    = mac_upd_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            arx_pkg::OP_LOAD_KEY:  cmd.key_we    = 1'b1;
            arx_pkg::OP_CTR_START: cmd.ctr_start = 1'b1;
            arx_pkg::OP_MAC_CLEAR: cmd.mac_clr   = 1'b1;
            arx_pkg::OP_ENCRYPT: begin
              cmd.blk_load = 1'b1;
              cmd.src      = arx_pkg::SRC_BLOCK;
              cmd.kind     = arx_pkg::KIND_ENC;
            end
            arx_pkg::OP_DECRYPT: begin
              cmd.blk_load = 1'b1;
              cmd.src      = arx_pkg::SRC_BLOCK;
              cmd.kind     = arx_pkg::KIND_DEC;
            end
            arx_pkg::OP_CTR_DATA: begin
              cmd.blk_load = 1'b1;
              cmd.src      = cnt_zero ? arx_pkg::SRC_ZERO : arx_pkg::SRC_CTR;
              cmd.kind     = arx_pkg::KIND_CTR;
            end
            arx_pkg::OP_MAC_DATA: begin
              cmd.blk_load = 1'b1;
              cmd.src      = cnt_zero ? arx_pkg::SRC_MAC : arx_pkg::SRC_MAC_MIX;
              cmd.kind     = arx_pkg::KIND_MAC;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        // On the last round, write straight to the output when it is free
        if (last_rnd && stat.out_free) begin
          cmd.push       = 1'b1;
          cmd.push_round = 1'b1;
        end else begin
          cmd.round_en   = 1'b1;
        end
      end
      ST_HOLD: begin
        if (stat.out_free) begin
          cmd.push = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Hold state, round counter and per-item flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rnd_r     <= '0;
      dec_r     <= 1'b0;
      ctr_adv_r <= 1'b0;
      mac_upd_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          rnd_r <= '0;
          if (accept) begin
            dec_r     <= (in_op == arx_pkg::OP_DECRYPT);
            ctr_adv_r <= (in_op == arx_pkg::OP_CTR_DATA) && !cnt_zero;
            mac_upd_r <= (in_op == arx_pkg::OP_MAC_DATA);
            if ((in_op == arx_pkg::OP_ENCRYPT) || (in_op == arx_pkg::OP_DECRYPT)) begin
              state_r <= ST_RUN;
            end else if ((in_op == arx_pkg::OP_CTR_DATA) ||
                         (in_op == arx_pkg::OP_MAC_DATA)) begin
              state_r <= cnt_zero ? ST_HOLD : ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (last_rnd) begin
            state_r <= stat.out_free ? ST_IDLE : ST_HOLD;
          end else begin
            rnd_r <= rnd_r + 1'b1;
          end
        end
        ST_HOLD: begin
          if (stat.out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // A result is only pushed into a free output slot
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> stat.out_free)
    else $error("push into occupied output slot");

  // Round counter stays inside the key table
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (rnd_r <= LAST_RND))
    else $error("round counter out of range");

  // A cipher request starts the round sequence
  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ((in_op == arx_pkg::OP_ENCRYPT) || (in_op == arx_pkg::OP_DECRYPT)))
      |=> (state_r == ST_RUN) && (rnd_r == '0))
    else $error("cipher request did not start rounds");

endmodule
`default_nettype wire

// ===== hw/rtl/arx_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARX cipher datapath
// Round-key table, working block, one round unit, stream and chain state,
// and the output register.
// ----------------------------------------------------------------------------
module arx_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire arx_pkg::arx_cmd_t             cmd,
  output arx_pkg::arx_stat_t                 stat,
  input  wire logic [arx_pkg::IDX_W-1:0]     in_round_index,
  input  wire logic [arx_pkg::WORD_W-1:0]    in_round_key_word,
  input  wire logic [arx_pkg::BLOCK_W-1:0]   in_block_in,
  input  wire logic [arx_pkg::CNT_W-1:0]     in_byte_count,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [arx_pkg::BLOCK_W-1:0]        out_result_block,
  output logic [arx_pkg::KIND_W-1:0]         out_result_kind
);

  logic [arx_pkg::WORD_W-1:0]  key_mem [arx_pkg::ROUNDS];
  logic [arx_pkg::WORD_W-1:0]  x_r, y_r;
  logic [arx_pkg::BLOCK_W-1:0] data_r, mask_r;
  logic [arx_pkg::KIND_W-1:0]  kind_r;
  logic [arx_pkg::BLOCK_W-1:0] nonce_r, ctr_r, mac_r;
  logic [arx_pkg::BLOCK_W-1:0] ctr_nxt;
  logic                        out_valid_r;
  logic [arx_pkg::BLOCK_W-1:0] out_block_r;
  logic [arx_pkg::KIND_W-1:0]  out_kind_r;

  logic [arx_pkg::WORD_W-1:0]  rk;
  logic [arx_pkg::WORD_W-1:0]  ex1, ey1, dx1, dy1;
  logic [arx_pkg::WORD_W-1:0]  x_nxt, y_nxt;
  logic [arx_pkg::BLOCK_W-1:0] in_mask;
  logic [arx_pkg::BLOCK_W-1:0] src_blk;
  logic [arx_pkg::BLOCK_W-1:0] fin_blk;
  logic [arx_pkg::BLOCK_W-1:0] res_blk;
  logic                        key_ok;

  assign stat.out_free = !out_valid_r || !out_stall;

  // Round key for the current round
  assign rk = key_mem[cmd.key_sel];

  // One forward round and one inverse round
  assign ex1 = {x_r[7:0], x_r[31:8]} + y_r;
  assign ey1 = {y_r[28:0], y_r[31:29]} ^ ex1;
  assign dx1 = x_r ^ rk;
  assign dy1 = {(y_r[2:0] ^ dx1[2:0]), (y_r[31:3] ^ dx1[31:3])};

  always_comb begin
    logic [arx_pkg::WORD_W-1:0] diff;
    diff = dx1 - dy1;
    if (cmd.dec) begin
      x_nxt = {diff[23:0], diff[31:24]};
      y_nxt = dy1;
    end else begin
      x_nxt = ex1 ^ rk;
      y_nxt = ey1;
    end
  end

  // Select the starting block of a new item
  assign in_mask = arx_pkg::byte_mask(in_byte_count);

  always_comb begin
    unique case (cmd.src)
      arx_pkg::SRC_BLOCK:   src_blk = in_block_in;
      arx_pkg::SRC_CTR:     src_blk = ctr_r;
      arx_pkg::SRC_MAC_MIX: src_blk = mac_r ^ (in_block_in & in_mask);
      arx_pkg::SRC_MAC:     src_blk = mac_r;
      arx_pkg::SRC_ZERO:    src_blk = '0;
      default:              src_blk = '0;
    endcase
  end

  // Finished block, then the stream mix for counter mode
  assign fin_blk = cmd.push_round ? {y_nxt, x_nxt} : {y_r, x_r};
  assign res_blk = (fin_blk & mask_r) ^ data_r;

  // Counter advance with reload from the nonce on wrap
  always_comb begin
    ctr_nxt = ctr_r + 64'd1;
    if (ctr_nxt == '0) begin
      ctr_nxt = nonce_r;
    end
  end

  assign key_ok = ({1'b0, in_round_index} < (arx_pkg::IDX_W + 1)'(arx_pkg::ROUNDS));

  // Write the round-key table
  always_ff @(posedge clk) begin
    if (cmd.key_we && key_ok) begin
      key_mem[in_round_index[arx_pkg::KEY_W-1:0]] <= in_round_key_word;
    end
  end

  // Load and advance the working block
  always_ff @(posedge clk) begin
    if (cmd.blk_load) begin
      x_r    <= src_blk[31:0];
      y_r    <= src_blk[63:32];
      kind_r <= cmd.kind;
      if (cmd.kind == arx_pkg::KIND_CTR) begin
        data_r <= in_block_in & in_mask;
        mask_r <= in_mask;
      end else begin
        data_r <= '0;
        mask_r <= '1;
      end
    end else if (cmd.round_en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  // Hold stream and chain state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonce_r <= '0;
      ctr_r   <= '0;
      mac_r   <= '0;
    end else begin
      if (cmd.ctr_start) begin
        nonce_r <= in_block_in;
        ctr_r   <= in_block_in;
      end else if (cmd.push && cmd.ctr_adv) begin
        ctr_r <= ctr_nxt;
      end
      if (cmd.mac_clr) begin
        mac_r <= '0;
      end else if (cmd.push && cmd.mac_upd) begin
        mac_r <= fin_blk;
      end
    end
  end

  // Output register: fill on push, drain on a taken beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_block_r <= res_blk;
      out_kind_r  <= kind_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_block = out_block_r;
  assign out_result_kind  = out_kind_r;

  // A push always presents a beat on the next cycle
  a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> out_valid_r)
    else $error("pushed result not presented");

  // The chain only moves on a clear or on a pushed chain result
  a_mac_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.push && !cmd.mac_clr) |=> $stable(mac_r))
    else $error("mac chain changed without cause");

  // The counter only moves on a start or on a pushed stream result
  a_ctr_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.push && !cmd.ctr_start) |=> $stable(ctr_r))
    else $error("stream counter changed without cause");

endmodule
`default_nettype wire

// ===== hw/rtl/arx_block_cipher_ctr_mac.sv =====
// Load key, ctr start, mac clear and unused opcodes complete in their accept cycle;
// encrypt, decrypt and ctr/mac data with bytes present run through every round after
// the accept cycle, one round per cycle; zero-byte data skips the rounds.
// Items are taken one at a time: the input stalls until the result is pushed, set by the
// single shared round unit iterating over the round-key table.
// Reset (synchronous): nonce, counter and chain clear to zero; key table unset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARX block cipher with CTR keystream and CBC-MAC
// Top level: controller and datapath joined by command and status bundles.
// ----------------------------------------------------------------------------
module arx_block_cipher_ctr_mac (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [arx_pkg::OP_W-1:0]      in_op,
  input  wire logic [arx_pkg::IDX_W-1:0]     in_round_index,
  input  wire logic [arx_pkg::WORD_W-1:0]    in_round_key_word,
  input  wire logic [arx_pkg::BLOCK_W-1:0]   in_block_in,
  input  wire logic [arx_pkg::CNT_W-1:0]     in_byte_count,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [arx_pkg::BLOCK_W-1:0]        out_result_block,
  output logic [arx_pkg::KIND_W-1:0]         out_result_kind
);

  arx_pkg::arx_cmd_t  cmd;
  arx_pkg::arx_stat_t stat;

  // Sequence each beat
  arx_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_op         (in_op),
    .in_byte_count (in_byte_count),
    .in_stall      (in_stall),
    .stat          (stat),
    .cmd           (cmd)
  );

  // Compute rounds and hold state
  arx_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_round_index    (in_round_index),
    .in_round_key_word (in_round_key_word),
    .in_block_in       (in_block_in),
    .in_byte_count     (in_byte_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_block  (out_result_block),
    .out_result_kind   (out_result_kind)
  );

endmodule
`default_nettype wire

// ===== verif/arx_block_cipher_ctr_mac_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARX cipher engine testbench
// Drives load-key, block, CTR and CBC-MAC beats through the valid/stall input
// channel and scores every result beat against a cycle-free predictor of the
// cipher, its keystream counter and its MAC chain. A directed table comes
// first, then randomized streams under changing back-pressure.
// ----------------------------------------------------------------------------
module arx_block_cipher_ctr_mac_tb;

  // Opcode the block decodes to nothing
  localparam logic [arx_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

  localparam int RANDOM_BEATS = 1200;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 4000;
  localparam int SETTLE       = 40;
  localparam int MAX_PRINTS   = 50;

  typedef struct {
    logic [arx_pkg::OP_W-1:0]    op;
    logic [arx_pkg::IDX_W-1:0]   idx;
    logic [arx_pkg::WORD_W-1:0]  kw;
    logic [arx_pkg::BLOCK_W-1:0] blk;
    logic [arx_pkg::CNT_W-1:0]   cnt;
    bit                          typed;
    logic [arx_pkg::BLOCK_W-1:0] typed_blk;
    logic [arx_pkg::KIND_W-1:0]  typed_kind;
  } item_t;

  typedef struct {
    logic [arx_pkg::BLOCK_W-1:0] blk;
    logic [arx_pkg::KIND_W-1:0]  kind;
  } beat_t;

  // DUT ports
  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [arx_pkg::OP_W-1:0]     in_op = '0;
  logic [arx_pkg::IDX_W-1:0]    in_round_index = '0;
  logic [arx_pkg::WORD_W-1:0]   in_round_key_word = '0;
  logic [arx_pkg::BLOCK_W-1:0]  in_block_in = '0;
  logic [arx_pkg::CNT_W-1:0]    in_byte_count = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [arx_pkg::BLOCK_W-1:0]  out_result_block;
  logic [arx_pkg::KIND_W-1:0]   out_result_kind;

  // Predictor state
  logic [arx_pkg::WORD_W-1:0]   key_tab [arx_pkg::ROUNDS];
  logic [arx_pkg::BLOCK_W-1:0]  ks_nonce = '0;
  logic [arx_pkg::BLOCK_W-1:0]  ks_count = '0;
  logic [arx_pkg::BLOCK_W-1:0]  mac_acc = '0;

  beat_t pending_results[$];

  int error_count = 0;
  int results_checked = 0;
  int beats_sent = 0;
  int wrap_count = 0;
  int send_idle_pct = 8;
  int recv_idle_pct = 47;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  arx_block_cipher_ctr_mac u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_round_index    (in_round_index),
    .in_round_key_word (in_round_key_word),
    .in_block_in       (in_block_in),
    .in_byte_count     (in_byte_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_block  (out_result_block),
    .out_result_kind   (out_result_kind)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Print one mismatch line (first few only) and count it
  task automatic report_mismatch(input string what,
                                 input logic [arx_pkg::BLOCK_W-1:0] got,
                                 input logic [arx_pkg::BLOCK_W-1:0] want);
    if (error_count < MAX_PRINTS) begin
      $display("[%0t] MISMATCH %s: got %h want %h", $realtime, what, got, want);
    end
    error_count++;
  endtask

  // Forward cipher over the whole round-key table
  function automatic logic [arx_pkg::BLOCK_W-1:0] cipher_fwd(
      input logic [arx_pkg::BLOCK_W-1:0] b);
    logic [arx_pkg::WORD_W-1:0] x;
    logic [arx_pkg::WORD_W-1:0] y;
    x = b[31:0];
    y = b[63:32];
    for (int r = 0; r < arx_pkg::ROUNDS; r++) begin
      x = {x[7:0], x[31:8]} + y;
      y = {y[28:0], y[31:29]} ^ x;
      x = x ^ key_tab[r];
    end
    return {y, x};
  endfunction

  // Inverse cipher, keys walked from the last round down
  function automatic logic [arx_pkg::BLOCK_W-1:0] cipher_inv(
      input logic [arx_pkg::BLOCK_W-1:0] b);
    logic [arx_pkg::WORD_W-1:0] x;
    logic [arx_pkg::WORD_W-1:0] y;
    logic [arx_pkg::WORD_W-1:0] t;
    x = b[31:0];
    y = b[63:32];
    for (int r = arx_pkg::ROUNDS - 1; r >= 0; r--) begin
      x = x ^ key_tab[r];
      t = y ^ x;
      y = {t[2:0], t[31:3]};
      t = x - y;
      x = {t[23:0], t[31:24]};
    end
    return {y, x};
  endfunction

  // Keep the low count bytes; counts of eight and up keep all
  function automatic logic [arx_pkg::BLOCK_W-1:0] valid_bytes(
      input logic [arx_pkg::CNT_W-1:0] c);
    if (c >= 8) return '1;
    return (64'd1 << (8 * c)) - 64'd1;
  endfunction

  // Advance the engine state by one beat; return 1 with the result if one is due
  function automatic bit engine_step(input item_t it, output beat_t r);
    r.blk  = '0;
    r.kind = arx_pkg::KIND_ENC;
    case (it.op)
      arx_pkg::OP_LOAD_KEY: begin
        if (it.idx < arx_pkg::ROUNDS) key_tab[it.idx] = it.kw;
        return 1'b0;
      end
      arx_pkg::OP_ENCRYPT: begin
        r.blk = cipher_fwd(it.blk);
        return 1'b1;
      end
      arx_pkg::OP_DECRYPT: begin
        r.blk  = cipher_inv(it.blk);
        r.kind = arx_pkg::KIND_DEC;
        return 1'b1;
      end
      arx_pkg::OP_CTR_START: begin
        ks_nonce = it.blk;
        ks_count = it.blk;
        return 1'b0;
      end
      arx_pkg::OP_CTR_DATA: begin
        r.kind = arx_pkg::KIND_CTR;
        if (it.cnt == 0) return 1'b1;
        r.blk = (it.blk ^ cipher_fwd(ks_count)) & valid_bytes(it.cnt);
        ks_count = ks_count + 64'd1;
        if (ks_count == '0) begin
          ks_count = ks_nonce;
          wrap_count++;
        end
        return 1'b1;
      end
      arx_pkg::OP_MAC_CLEAR: begin
        mac_acc = '0;
        return 1'b0;
      end
      arx_pkg::OP_MAC_DATA: begin
        if (it.cnt != 0) mac_acc = cipher_fwd(mac_acc ^ (it.blk & valid_bytes(it.cnt)));
        r.blk  = mac_acc;
        r.kind = arx_pkg::KIND_MAC;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic item_t mk(input logic [arx_pkg::OP_W-1:0] op,
                               input logic [arx_pkg::IDX_W-1:0] idx,
                               input logic [arx_pkg::WORD_W-1:0] kw,
                               input logic [arx_pkg::BLOCK_W-1:0] blk,
                               input logic [arx_pkg::CNT_W-1:0] cnt);
    item_t it;
    it.op = op;
    it.idx = idx;
    it.kw = kw;
    it.blk = blk;
    it.cnt = cnt;
    it.typed = 1'b0;
    it.typed_blk = '0;
    it.typed_kind = arx_pkg::KIND_ENC;
    return it;
  endfunction

  function automatic item_t mk_typed(input logic [arx_pkg::OP_W-1:0] op,
                                     input logic [arx_pkg::BLOCK_W-1:0] blk,
                                     input logic [arx_pkg::CNT_W-1:0] cnt,
                                     input logic [arx_pkg::BLOCK_W-1:0] want_blk,
                                     input logic [arx_pkg::KIND_W-1:0] want_kind);
    item_t it;
    it = mk(op, '0, '0, blk, cnt);
    it.typed = 1'b1;
    it.typed_blk = want_blk;
    it.typed_kind = want_kind;
    return it;
  endfunction

  function automatic logic [arx_pkg::CNT_W-1:0] rand_count();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return arx_pkg::CNT_W'($urandom_range(8, 1));
    if (pick < 85) return '0;
    return arx_pkg::CNT_W'($urandom_range(15, 9));
  endfunction

  // Every field random, op as given
  function automatic item_t noise_item(input logic [arx_pkg::OP_W-1:0] op);
    return mk(op, arx_pkg::IDX_W'($urandom_range(63)), $urandom, {$urandom, $urandom},
              rand_count());
  endfunction

  // Offer one beat, hold it until accepted, then queue its expected result
  task automatic send_beat(input item_t it);
    beat_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid          <= 1'b1;
    in_op             <= it.op;
    in_round_index    <= it.idx;
    in_round_key_word <= it.kw;
    in_block_in       <= it.blk;
    in_byte_count     <= it.cnt;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (engine_step(it, r)) begin
      if (it.typed) begin
        r.blk  = it.typed_blk;
        r.kind = it.typed_kind;
      end
      pending_results.push_back(r);
    end
    beats_sent++;
  endtask

  // Receiver: score accepted result beats, then pick next cycle's stall
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", out_result_block, '0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_result_block !== want.blk)
          report_mismatch("result_block", out_result_block, want.blk);
        if (out_result_kind !== want.kind)
          report_mismatch("result_kind", arx_pkg::BLOCK_W'(out_result_kind),
                          arx_pkg::BLOCK_W'(want.kind));
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Stimulus
  initial begin
    item_t plan[$];
    item_t it;
    int directed_beats;
    int random_beats;
    int phase;
    int cur_phase;
    int run_len;
    int pick;
    int wait_cycles;

    random_beats = 0;
    cur_phase = 0;

    // Before any key is loaded: only beats that never touch the key table
    plan.push_back(mk_typed(arx_pkg::OP_CTR_DATA, '1, 4'd0, '0, arx_pkg::KIND_CTR));
    plan.push_back(mk_typed(arx_pkg::OP_MAC_DATA, '1, 4'd0, '0, arx_pkg::KIND_MAC));
    plan.push_back(mk(arx_pkg::OP_LOAD_KEY, 6'd63, '1, '1, 4'd15));
    plan.push_back(mk(arx_pkg::OP_LOAD_KEY, arx_pkg::IDX_W'(arx_pkg::ROUNDS), '1, '0, 4'd0));
    plan.push_back(mk(OP_UNUSED, 6'd63, '1, '1, 4'd15));
    plan.push_back(mk(arx_pkg::OP_MAC_CLEAR, '0, '0, '1, 4'd8));
    // Fill the key table, extremes in the first and last slot
    for (int k = 0; k < arx_pkg::ROUNDS; k++) begin
      plan.push_back(mk(arx_pkg::OP_LOAD_KEY, arx_pkg::IDX_W'(k),
                        (k == 0) ? '1 : (k == arx_pkg::ROUNDS - 1) ? '0 : $urandom,
                        '0, '0));
    end
    // Block extremes, data before any CTR start, counter wrap, count saturation
    plan.push_back(mk(arx_pkg::OP_ENCRYPT, '0, '0, '0, 4'd0));
    plan.push_back(mk(arx_pkg::OP_ENCRYPT, '0, '0, '1, 4'd0));
    plan.push_back(mk(arx_pkg::OP_DECRYPT, '0, '0, '0, 4'd0));
    plan.push_back(mk(arx_pkg::OP_DECRYPT, '0, '0, '1, 4'd0));
    plan.push_back(mk(arx_pkg::OP_CTR_DATA, '0, '0, 64'h0123_4567_89ab_cdef, 4'd8));
    plan.push_back(mk(arx_pkg::OP_CTR_START, '0, '0, '1, 4'd0));
    plan.push_back(mk(arx_pkg::OP_CTR_DATA, '0, '0, '1, 4'd8));
    plan.push_back(mk(arx_pkg::OP_CTR_DATA, '0, '0, '1, 4'd1));
    plan.push_back(mk(arx_pkg::OP_CTR_DATA, '0, '0, '1, 4'd15));
    plan.push_back(mk_typed(arx_pkg::OP_CTR_DATA, '1, 4'd0, '0, arx_pkg::KIND_CTR));
    plan.push_back(mk(arx_pkg::OP_CTR_START, '0, '0, 64'hffff_ffff_ffff_fffe, 4'd0));
    plan.push_back(mk(arx_pkg::OP_CTR_DATA, '0, '0, 64'h8877_6655_4433_2211, 4'd7));
    plan.push_back(mk(arx_pkg::OP_CTR_DATA, '0, '0, '1, 4'd9));
    plan.push_back(mk(arx_pkg::OP_CTR_DATA, '0, '0, '1, 4'd3));
    plan.push_back(mk(arx_pkg::OP_MAC_DATA, '0, '0, '1, 4'd8));
    plan.push_back(mk(arx_pkg::OP_MAC_DATA, '0, '0, '1, 4'd9));
    plan.push_back(mk(arx_pkg::OP_MAC_DATA, '0, '0, '1, 4'd1));
    plan.push_back(mk(arx_pkg::OP_MAC_DATA, '0, '0, '1, 4'd0));
    plan.push_back(mk(arx_pkg::OP_MAC_CLEAR, '0, '0, '0, 4'd0));
    plan.push_back(mk_typed(arx_pkg::OP_MAC_DATA, '1, 4'd0, '0, arx_pkg::KIND_MAC));

    // Hold reset, then release once
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (plan[i]) send_beat(plan[i]);
    directed_beats = beats_sent;

    // Random streams; back-pressure profile changes every third of the run
    while (random_beats < RANDOM_BEATS) begin
      phase = random_beats * 3 / RANDOM_BEATS;
      if (phase != cur_phase) begin
        cur_phase = phase;
        if (phase == 1) begin
          send_idle_pct = 47;
          recv_idle_pct <= 8;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
          hold_req <= 1'b1;
        end
      end
      pick = $urandom_range(99);
      if (pick < 30) begin
        // CTR stream, sometimes with a nonce that wraps soon
        it = noise_item(arx_pkg::OP_CTR_START);
        if ($urandom_range(5) == 0) it.blk = '1 - arx_pkg::BLOCK_W'($urandom_range(3));
        send_beat(it);
        random_beats++;
        run_len = $urandom_range(8, 1);
        repeat (run_len) begin
          send_beat(noise_item(arx_pkg::OP_CTR_DATA));
          random_beats++;
        end
      end else if (pick < 60) begin
        // MAC message, usually from a cleared chain
        if ($urandom_range(3) != 0) begin
          send_beat(noise_item(arx_pkg::OP_MAC_CLEAR));
          random_beats++;
        end
        run_len = $urandom_range(8, 1);
        repeat (run_len) begin
          it = noise_item(arx_pkg::OP_MAC_DATA);
          if ($urandom_range(15) == 0) it.blk = ($urandom_range(1) != 0) ? '1 : '0;
          send_beat(it);
          random_beats++;
        end
      end else if (pick < 80) begin
        it = noise_item(($urandom_range(1) != 0) ? arx_pkg::OP_ENCRYPT : arx_pkg::OP_DECRYPT);
        if ($urandom_range(15) == 0) it.blk = ($urandom_range(1) != 0) ? '1 : '0;
        send_beat(it);
        random_beats++;
      end else if (pick < 90) begin
        // Rekey one slot; slots past the table are dropped by the block
        it = noise_item(arx_pkg::OP_LOAD_KEY);
        send_beat(it);
        if (it.idx < arx_pkg::ROUNDS) random_beats++;
      end else begin
        it = noise_item(arx_pkg::OP_W'($urandom_range(7)));
        send_beat(it);
        if (it.op != OP_UNUSED &&
            !(it.op == arx_pkg::OP_LOAD_KEY && it.idx >= arx_pkg::ROUNDS))
          random_beats++;
      end
    end
    in_valid <= 1'b0;

    // Drain, then let the pipeline settle
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("expected results never arrived",
                      arx_pkg::BLOCK_W'(pending_results.size()), '0);

    $display("Covered %0d input beats (%0d directed), %0d result beats scored.",
             beats_sent, directed_beats, results_checked);
    $display("Counter wraps: %0d; long receiver hold applied: %0d; mismatches: %0d.",
             wrap_count, hold_done, error_count);
    if (error_count == 0) begin
      $display("arx_block_cipher_ctr_mac_tb passed");
    end else begin
      $display("arx_block_cipher_ctr_mac_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("arx_block_cipher_ctr_mac_tb failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/arx_pkg.sv
hw/rtl/arx_ctrl.sv
hw/rtl/arx_dp.sv
hw/rtl/arx_block_cipher_ctr_mac.sv
verif/arx_block_cipher_ctr_mac_tb.sv
